### hdl/esd_pkg.sv
`default_nettype none

package esd_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX   = 3'd2,
        PH_DEC   = 3'd3,
        PH_OCT   = 3'd4,
        PH_CARET = 3'd5
    } phase_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SJIS_MODE  = 1'd1;

    // Characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_B      = 8'h62;
    localparam logic [7:0] CH_LC_D      = 8'h64;
    localparam logic [7:0] CH_LC_E      = 8'h65;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_LC_T      = 8'h74;
    localparam logic [7:0] CH_LC_V      = 8'h76;
    localparam logic [7:0] CH_LC_X      = 8'h78;
    localparam logic [7:0] CH_LC_Z      = 8'h7A;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_HT        = 8'h09;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CASE_BIT     = 8'h20;
    localparam logic [7:0] CTRL_BIT     = 8'h40;

    // Shift-JIS lead byte ranges
    localparam logic [7:0] SJIS_LO1 = 8'h81;
    localparam logic [7:0] SJIS_HI1 = 8'h9F;
    localparam logic [7:0] SJIS_LO2 = 8'hE0;
    localparam logic [7:0] SJIS_HI2 = 8'hFC;

    // One decoded result
    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       eos;
    } res_t;

    // Results of one input item, handed from front to back
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } job_t;

    localparam res_t RES_END = '{data: 8'h00, bval: 1'b0, eos: 1'b1};

    function automatic res_t res_byte(input logic [7:0] b);
        res_t r;
        r.data = b;
        r.bval = 1'b1;
        r.eos  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/esd_front.sv
`default_nettype none

module esd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          accept,
    input  wire logic [7:0]                    in_byte,
    output logic                               push,
    output esd_pkg::job_t                      job
);

    esd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] acc_reg, acc_next;
    logic [7:0] pb_reg, pb_next;
    logic       pv_reg, pv_next;
    logic [7:0] term_reg;
    logic       sjis_reg;
    logic       has;

    // Classification of the incoming byte
    logic       p_end, p_esc, is_digit, is_oct, hex_ok, lead, map_ok;
    logic [3:0] hex_val, dig;
    logic [7:0] map_val, caret_val, acc_hex, acc_dec, acc_oct;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
            sjis_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == esd_pkg::CFG_TERMINATOR)
                term_reg <= cfg_data;
            else if (cfg_index == esd_pkg::CFG_SJIS_MODE)
                sjis_reg <= cfg_data[0];
        end
    end

    always_comb
    begin
        lead = ((pb_reg >= esd_pkg::SJIS_LO1) && (pb_reg <= esd_pkg::SJIS_HI1)) ||
               ((pb_reg >= esd_pkg::SJIS_LO2) && (pb_reg <= esd_pkg::SJIS_HI2));
        p_end = (in_byte == esd_pkg::CH_NUL) || (in_byte == term_reg);
        p_esc = (in_byte == esd_pkg::CH_BACKSLASH) && !(sjis_reg && pv_reg && lead);
        dig      = 4'(in_byte - esd_pkg::CH_ZERO);
        is_digit = (in_byte >= esd_pkg::CH_ZERO) && (in_byte <= esd_pkg::CH_NINE);
        is_oct   = (in_byte >= esd_pkg::CH_ZERO) && (in_byte <= esd_pkg::CH_SEVEN);
        // hex digit value
        hex_ok  = 1'b1;
        hex_val = dig;
        if (is_digit)
            hex_val = dig;
        else if ((in_byte >= esd_pkg::CH_LC_A) && (in_byte <= esd_pkg::CH_LC_F))
            hex_val = 4'(in_byte - esd_pkg::CH_LC_A + 8'd10);
        else if ((in_byte >= esd_pkg::CH_UC_A) && (in_byte <= esd_pkg::CH_UC_F))
            hex_val = 4'(in_byte - esd_pkg::CH_UC_A + 8'd10);
        else
            hex_ok = 1'b0;
        acc_hex = {acc_reg[3:0], hex_val};
        acc_oct = {acc_reg[4:0], 3'b000} | {4'b0000, dig};
        acc_dec = {acc_reg[4:0], 3'b000} + {acc_reg[6:0], 1'b0} + {4'b0000, dig};
        // control character: upper-case letters, then flip bit 6
        if ((in_byte >= esd_pkg::CH_LC_A) && (in_byte <= esd_pkg::CH_LC_Z))
            caret_val = (in_byte - esd_pkg::CASE_BIT) ^ esd_pkg::CTRL_BIT;
        else
            caret_val = in_byte ^ esd_pkg::CTRL_BIT;
    end

    // Single-character escape map
    always_comb
    begin
        map_ok  = 1'b1;
        map_val = in_byte;
        unique case (in_byte)
            esd_pkg::CH_LC_A:      map_val = esd_pkg::CH_BEL;
            esd_pkg::CH_LC_B:      map_val = esd_pkg::CH_BS;
            esd_pkg::CH_LC_E:      map_val = esd_pkg::CH_ESC;
            esd_pkg::CH_LC_F:      map_val = esd_pkg::CH_FF;
            esd_pkg::CH_LC_T:      map_val = esd_pkg::CH_HT;
            esd_pkg::CH_LC_V:      map_val = esd_pkg::CH_VT;
            esd_pkg::CH_BACKSLASH,
            esd_pkg::CH_QUOTE,
            esd_pkg::CH_DQUOTE,
            esd_pkg::CH_DOT:       map_val = in_byte;
            default:               map_ok  = 1'b0;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            esd_pkg::PH_ESC:
            begin
                if (in_byte == esd_pkg::CH_NUL)
                    phase_next = esd_pkg::PH_PLAIN;
                else if (in_byte == esd_pkg::CH_LC_X)
                    phase_next = esd_pkg::PH_HEX;
                else if (in_byte == esd_pkg::CH_LC_D)
                    phase_next = esd_pkg::PH_DEC;
                else if (in_byte == esd_pkg::CH_CARET)
                    phase_next = esd_pkg::PH_CARET;
                else if (is_oct)
                    phase_next = esd_pkg::PH_OCT;
                else
                    phase_next = esd_pkg::PH_PLAIN;
            end
            esd_pkg::PH_HEX:
            begin
                if (!hex_ok)
                    phase_next = (!p_end && p_esc) ? esd_pkg::PH_ESC : esd_pkg::PH_PLAIN;
            end
            esd_pkg::PH_DEC,
            esd_pkg::PH_OCT:
            begin
                if (!is_digit)
                    phase_next = (!p_end && p_esc) ? esd_pkg::PH_ESC : esd_pkg::PH_PLAIN;
            end
            esd_pkg::PH_CARET:
                phase_next = esd_pkg::PH_PLAIN;
            default:
                phase_next = (!p_end && p_esc) ? esd_pkg::PH_ESC : esd_pkg::PH_PLAIN;
        endcase
    end

    // Results and datapath state
    always_comb
    begin
        acc_next = acc_reg;
        pb_next  = in_byte;
        pv_next  = 1'b1;
        has      = 1'b0;
        job      = '0;
        unique case (phase_reg)
            esd_pkg::PH_ESC:
            begin
                if (in_byte == esd_pkg::CH_NUL)
                begin
                    has    = 1'b1;
                    job.r0 = esd_pkg::RES_END;
                end
                else
                begin
                    has    = map_ok;
                    job.r0 = esd_pkg::res_byte(map_val);
                    if ((in_byte == esd_pkg::CH_LC_X) || (in_byte == esd_pkg::CH_LC_D))
                        acc_next = '0;
                    else if (is_oct)
                        acc_next = {4'b0000, dig};
                end
            end
            esd_pkg::PH_HEX,
            esd_pkg::PH_DEC,
            esd_pkg::PH_OCT:
            begin
                if ((phase_reg == esd_pkg::PH_HEX) ? hex_ok : is_digit)
                begin
                    if (phase_reg == esd_pkg::PH_HEX)
                        acc_next = acc_hex;
                    else if (phase_reg == esd_pkg::PH_DEC)
                        acc_next = acc_dec;
                    else
                        acc_next = acc_oct;
                end
                else
                begin
                    // value first, then the byte as plain text
                    has    = 1'b1;
                    job.r0 = esd_pkg::res_byte(acc_reg);
                    if (p_end)
                    begin
                        job.two = 1'b1;
                        job.r1  = esd_pkg::RES_END;
                    end
                    else if (!p_esc)
                    begin
                        job.two = 1'b1;
                        job.r1  = esd_pkg::res_byte(in_byte);
                    end
                end
            end
            esd_pkg::PH_CARET:
            begin
                has = 1'b1;
                if (in_byte == esd_pkg::CH_NUL)
                    job.r0 = esd_pkg::RES_END;
                else
                    job.r0 = esd_pkg::res_byte(caret_val);
            end
            default:
            begin
                if (p_end)
                begin
                    has    = 1'b1;
                    job.r0 = esd_pkg::RES_END;
                end
                else if (!p_esc)
                begin
                    has    = 1'b1;
                    job.r0 = esd_pkg::res_byte(in_byte);
                end
            end
        endcase
        // string ended: clear per-string state
        if ((has && job.r0.eos) || (job.two && job.r1.eos))
        begin
            acc_next = '0;
            pb_next  = '0;
            pv_next  = 1'b0;
        end
    end

    assign push = accept && has;

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esd_pkg::PH_PLAIN;
            acc_reg   <= '0;
            pb_reg    <= '0;
            pv_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pb_reg    <= pb_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

`default_nettype wire

### hdl/esd_queue.sv
`default_nettype none

module esd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire esd_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output esd_pkg::job_t      pop_data,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    esd_pkg::job_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

### hdl/esd_back.sv
`default_nettype none

module esd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire esd_pkg::job_t job,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               end_of_string,
    output logic               last
);

    logic         valid_reg;
    logic         half_reg, half_next;
    esd_pkg::res_t res_reg, res_next;
    logic         last_reg, last_next;
    logic         load;

    // Output register free or draining
    assign load = !valid_reg || !out_stall;

    // Select the next result of the head item
    always_comb
    begin
        half_next = half_reg;
        pop       = 1'b0;
        res_next  = job.r0;
        last_next = 1'b1;
        if (load && !empty)
        begin
            if (job.two && !half_reg)
            begin
                last_next = 1'b0;
                half_next = 1'b1;
            end
            else
            begin
                res_next  = half_reg ? job.r1 : job.r0;
                pop       = 1'b1;
                half_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (load)
                valid_reg <= !empty;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = res_reg.data;
    assign byte_valid    = res_reg.bval;
    assign end_of_string = res_reg.eos;
    assign last          = last_reg;

endmodule

`default_nettype wire

### hdl/escape_sequence_decoder.sv
// A result passes through the queue and the output register after its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; a byte with two results
// uses the single output register in turn, draining one result per cycle unless stalled.
// Bytes with no result (escape prefixes, digits) are accepted and emit nothing.
// Reset (rst_n, asynchronous, active low) returns to plain text, clears the queue,
// the output register valid and both configuration registers.
`default_nettype none

module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    in_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic                               end_of_string,
    output logic                               last
);

    esd_pkg::job_t push_job, head_job;
    logic          push, pop, full, empty, accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    // Front: classify bytes, track escape state
    esd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (in_byte),
        .push      (push),
        .job       (push_job)
    );

    // Queue between front and back
    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (empty)
    );

    // Back: serialize results onto the output channel
    esd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .last          (last)
    );

endmodule

`default_nettype wire

### hdl/esd_checker.sv
`default_nettype none

module esd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [7:0]                    in_byte,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [7:0]                    out_byte,
    input wire logic                          byte_valid,
    input wire logic                          end_of_string,
    input wire logic                          last
);

    // Stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("stalled input changed");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) &&
            $stable(byte_valid) && $stable(end_of_string) && $stable(last))
        else $error("stalled result changed");

    // A result without a byte is an end marker with zero data
    a_nobyte_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_string && (out_byte == 8'h00))
        else $error("empty result is not an end marker");

    // End marker is always the final result of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last)
        else $error("end marker not final");

    // Second result follows the first without a gap
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last && !out_stall |=> out_valid)
        else $error("second result missing");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

`default_nettype wire

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          RANDOM_PER_SETTING = 150;

    // One decoded result as the block reports it
    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       eos;
        logic       lst;
    } out_item_t;

    // Directed script row; t_* hold a hand-typed first result where typed is set
    typedef struct {
        logic [7:0] b;
        bit         typed;
        logic [7:0] t_data;
        bit         t_bval;
        bit         t_eos;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [esd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    in_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic [7:0]                    out_byte;
    logic                          byte_valid;
    logic                          end_of_string;
    logic                          last;

    escape_sequence_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .end_of_string(end_of_string),
        .last         (last)
    );

    // Decoder mirror: state and register copies
    esd_pkg::phase_t ph;
    logic [7:0]      acc;
    logic [7:0]      prev_b;
    bit              prev_v;
    logic [7:0]      term_reg;
    bit              sjis_reg;

    out_item_t  step_res[$];
    out_item_t  decoded_q[$];
    logic [7:0] byte_plan[$];

    int          errors = 0;
    int          row_errors = 0;
    int unsigned cycles = 0;
    bit          calm;

    // Short directed strings at reset settings (NUL-only end, Shift-JIS off)
    row_t script [25] = '{
        '{8'h41,                 1, 8'h41,           1, 0},
        '{8'hFF,                 1, 8'hFF,           1, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_LC_T,      1, esd_pkg::CH_HT,  1, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_LC_X,      0, 8'h00,           0, 0},
        '{esd_pkg::CH_LC_F,      0, 8'h00,           0, 0},
        '{esd_pkg::CH_UC_F,      0, 8'h00,           0, 0},
        '{esd_pkg::CH_BACKSLASH, 1, 8'hFF,           1, 0},
        '{esd_pkg::CH_LC_D,      0, 8'h00,           0, 0},
        '{esd_pkg::CH_NUL,       1, 8'h00,           1, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_CARET,     0, 8'h00,           0, 0},
        '{esd_pkg::CH_LC_Z,      1, 8'h1A,           1, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_SEVEN,     0, 8'h00,           0, 0},
        '{esd_pkg::CH_NINE,      0, 8'h00,           0, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{8'h71,                 0, 8'h00,           0, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_NUL,       1, 8'h00,           0, 1},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_DOT,       1, esd_pkg::CH_DOT, 1, 0},
        '{esd_pkg::CH_BACKSLASH, 0, 8'h00,           0, 0},
        '{esd_pkg::CH_LC_V,      1, esd_pkg::CH_VT,  1, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Prediction helpers
    function automatic void put_result(logic [7:0] d, bit v, bit e);
        out_item_t r;
        r.data = v ? d : 8'h00;
        r.bval = v;
        r.eos  = e;
        r.lst  = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void close_string();
        put_result(8'h00, 1'b0, 1'b1);
        ph     = esd_pkg::PH_PLAIN;
        acc    = 8'h00;
        prev_b = 8'h00;
        prev_v = 1'b0;
    endfunction

    // Ordinary text: end check, escape start, or literal byte
    function automatic void plain_byte(logic [7:0] b);
        bit lead;
        lead = (prev_b >= esd_pkg::SJIS_LO1 && prev_b <= esd_pkg::SJIS_HI1) ||
               (prev_b >= esd_pkg::SJIS_LO2 && prev_b <= esd_pkg::SJIS_HI2);
        if (b == esd_pkg::CH_NUL || b == term_reg)
        begin
            close_string();
            return;
        end
        if (b == esd_pkg::CH_BACKSLASH && !(sjis_reg && prev_v && lead))
            ph = esd_pkg::PH_ESC;
        else
        begin
            ph = esd_pkg::PH_PLAIN;
            put_result(b, 1'b1, 1'b0);
        end
        prev_b = b;
        prev_v = 1'b1;
    endfunction

    // Expected results of one accepted byte, appended to decoded_q
    function automatic void decode_step(logic [7:0] b);
        int        mapped;
        logic [7:0] u;
        logic [3:0] nib;
        bit         is_hex;
        out_item_t  t;
        step_res.delete();
        mapped = -1;
        is_hex = 1'b1;
        nib    = 4'd0;
        case (ph)
            esd_pkg::PH_ESC:
            begin
                if (b == esd_pkg::CH_NUL)
                    close_string();
                else
                begin
                    ph = esd_pkg::PH_PLAIN;
                    case (b)
                        esd_pkg::CH_LC_A: mapped = esd_pkg::CH_BEL;
                        esd_pkg::CH_LC_B: mapped = esd_pkg::CH_BS;
                        esd_pkg::CH_LC_E: mapped = esd_pkg::CH_ESC;
                        esd_pkg::CH_LC_F: mapped = esd_pkg::CH_FF;
                        esd_pkg::CH_LC_T: mapped = esd_pkg::CH_HT;
                        esd_pkg::CH_LC_V: mapped = esd_pkg::CH_VT;
                        esd_pkg::CH_BACKSLASH, esd_pkg::CH_QUOTE,
                        esd_pkg::CH_DQUOTE, esd_pkg::CH_DOT:
                            mapped = b;
                        esd_pkg::CH_LC_X:
                        begin
                            ph  = esd_pkg::PH_HEX;
                            acc = 8'h00;
                        end
                        esd_pkg::CH_LC_D:
                        begin
                            ph  = esd_pkg::PH_DEC;
                            acc = 8'h00;
                        end
                        esd_pkg::CH_CARET: ph = esd_pkg::PH_CARET;
                        default:
                        begin
                            if (b >= esd_pkg::CH_ZERO && b <= esd_pkg::CH_SEVEN)
                            begin
                                ph  = esd_pkg::PH_OCT;
                                acc = b - esd_pkg::CH_ZERO;
                            end
                        end
                    endcase
                    if (mapped >= 0)
                        put_result(mapped[7:0], 1'b1, 1'b0);
                    prev_b = b;
                    prev_v = 1'b1;
                end
            end
            esd_pkg::PH_HEX:
            begin
                if (b >= esd_pkg::CH_ZERO && b <= esd_pkg::CH_NINE)
                    nib = 4'(b - esd_pkg::CH_ZERO);
                else if (b >= esd_pkg::CH_LC_A && b <= esd_pkg::CH_LC_F)
                    nib = 4'(b - esd_pkg::CH_LC_A + 10);
                else if (b >= esd_pkg::CH_UC_A && b <= esd_pkg::CH_UC_F)
                    nib = 4'(b - esd_pkg::CH_UC_A + 10);
                else
                    is_hex = 1'b0;
                if (is_hex)
                begin
                    acc    = {acc[3:0], nib};
                    prev_b = b;
                    prev_v = 1'b1;
                end
                else
                begin
                    put_result(acc, 1'b1, 1'b0);
                    ph = esd_pkg::PH_PLAIN;
                    plain_byte(b);
                end
            end
            esd_pkg::PH_DEC, esd_pkg::PH_OCT:
            begin
                if (b >= esd_pkg::CH_ZERO && b <= esd_pkg::CH_NINE)
                begin
                    if (ph == esd_pkg::PH_DEC)
                        acc = 8'(acc * 10 + (b - esd_pkg::CH_ZERO));
                    else
                        acc = 8'((acc << 3) | (b - esd_pkg::CH_ZERO));
                    prev_b = b;
                    prev_v = 1'b1;
                end
                else
                begin
                    put_result(acc, 1'b1, 1'b0);
                    ph = esd_pkg::PH_PLAIN;
                    plain_byte(b);
                end
            end
            esd_pkg::PH_CARET:
            begin
                if (b == esd_pkg::CH_NUL)
                    close_string();
                else
                begin
                    u = (b >= esd_pkg::CH_LC_A && b <= esd_pkg::CH_LC_Z) ?
                        b - esd_pkg::CASE_BIT : b;
                    put_result(u ^ esd_pkg::CTRL_BIT, 1'b1, 1'b0);
                    ph     = esd_pkg::PH_PLAIN;
                    prev_b = b;
                    prev_v = 1'b1;
                end
            end
            default: plain_byte(b);
        endcase
        if (step_res.size() > 0)
        begin
            t = step_res.pop_back();
            t.lst = 1'b1;
            step_res.push_back(t);
        end
        foreach (step_res[i])
            decoded_q.push_back(step_res[i]);
    endfunction

    // Random text: mostly well-formed escapes, some noise and cut-off sequences
    function automatic void add_token();
        string      hexc   = "0123456789abcdefABCDEF";
        string      simple = "abeftv\\'\".";
        logic [7:0] leads [8] = '{8'h81, 8'h9F, 8'hE0, 8'hFC, 8'h80, 8'hA0, 8'hDF, 8'hFD};
        int         n;
        case ($urandom_range(0, 15))
            3: byte_plan.push_back(8'($urandom_range(0, 255)));
            4, 5:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(simple[$urandom_range(0, 9)]);
            end
            6:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(esd_pkg::CH_LC_X);
                n = $urandom_range(0, 3);
                repeat (n) byte_plan.push_back(hexc[$urandom_range(0, 21)]);
            end
            7:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(esd_pkg::CH_LC_D);
                n = $urandom_range(0, 4);
                repeat (n) byte_plan.push_back(8'(esd_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            8:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(8'(esd_pkg::CH_ZERO + $urandom_range(0, 7)));
                n = $urandom_range(0, 3);
                repeat (n) byte_plan.push_back(8'(esd_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            9:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(esd_pkg::CH_CARET);
                if ($urandom_range(0, 1))
                    byte_plan.push_back(8'(esd_pkg::CH_LC_A + $urandom_range(0, 25)));
                else
                    byte_plan.push_back(8'($urandom_range(1, 255)));
            end
            10:
            begin
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                byte_plan.push_back(8'($urandom_range(0, 255)));
            end
            11:
            begin
                // Shift-JIS lead byte (or a near miss) followed by a backslash
                if ($urandom_range(0, 1))
                    byte_plan.push_back(leads[$urandom_range(0, 7)]);
                else if ($urandom_range(0, 1))
                    byte_plan.push_back(8'($urandom_range(esd_pkg::SJIS_LO1,
                                                          esd_pkg::SJIS_HI1)));
                else
                    byte_plan.push_back(8'($urandom_range(esd_pkg::SJIS_LO2,
                                                          esd_pkg::SJIS_HI2)));
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                if ($urandom_range(0, 1))
                    byte_plan.push_back(simple[$urandom_range(0, 9)]);
                else
                    byte_plan.push_back(8'($urandom_range(1, 255)));
            end
            12:
            begin
                if (term_reg != 8'h00 && $urandom_range(0, 1))
                    byte_plan.push_back(term_reg);
                else
                    byte_plan.push_back(esd_pkg::CH_NUL);
            end
            13:
            begin
                // escape cut short by the end of the string
                byte_plan.push_back(esd_pkg::CH_BACKSLASH);
                n = $urandom_range(0, 2);
                if (n == 1)
                    byte_plan.push_back(esd_pkg::CH_CARET);
                else if (n == 2)
                    byte_plan.push_back(esd_pkg::CH_LC_X);
                if (term_reg != 8'h00 && $urandom_range(0, 1))
                    byte_plan.push_back(term_reg);
                else
                    byte_plan.push_back(esd_pkg::CH_NUL);
            end
            default: byte_plan.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
    endfunction

    // Offer one byte, hold it through stalls, predict on acceptance
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_step(b);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [esd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == esd_pkg::CFG_TERMINATOR)
            term_reg = val;
        else
            sjis_reg = val[0];
        @(negedge clk);
    endtask

    // Wait for the block to drain; bytes without results may still be in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Output checker
    always @(posedge clk)
    begin : out_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors + row_errors <= 10)
                    $display("unexpected result: byte=%h bval=%b eos=%b last=%b",
                             out_byte, byte_valid, end_of_string, last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (want.data !== out_byte || want.bval !== byte_valid ||
                    want.eos !== end_of_string || want.lst !== last)
                begin
                    errors++;
                    if (errors + row_errors <= 10)
                        $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.data, want.bval, want.eos, want.lst,
                                 out_byte, byte_valid, end_of_string, last);
                end
            end
        end
    end

    // Receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    // Main sequence
    initial
    begin : main_seq
        logic [7:0] terms [6];
        bit         sjis_sel [6];
        out_item_t  first;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 8'h00;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        calm      = 1'b0;
        ph        = esd_pkg::PH_PLAIN;
        acc       = 8'h00;
        prev_b    = 8'h00;
        prev_v    = 1'b0;
        term_reg  = 8'h00;
        sjis_reg  = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings
        foreach (script[i])
        begin
            send_byte(script[i].b);
            if (script[i].typed)
            begin
                first = (step_res.size() > 0) ? step_res[0] : '0;
                if (step_res.size() == 0 || first.data !== script[i].t_data ||
                    first.bval !== script[i].t_bval || first.eos !== script[i].t_eos)
                begin
                    row_errors++;
                    if (errors + row_errors <= 10)
                        $display("row %0d: predicted %h/%b/%b, table %h/%b/%b",
                                 i, first.data, first.bval, first.eos,
                                 script[i].t_data, script[i].t_bval, script[i].t_eos);
                end
            end
        end

        // Random text under several register settings
        terms    = '{8'hFF, 8'h74, 8'h78, 8'($urandom_range(1, 255)), 8'h01, 8'h00};
        sjis_sel = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_reg(esd_pkg::CFG_TERMINATOR, terms[p]);
            write_reg(esd_pkg::CFG_SJIS_MODE, {7'd0, sjis_sel[p]});
            cfg_valid <= 1'b0;
            calm = (p == 5);
            byte_plan.delete();
            while (byte_plan.size() < RANDOM_PER_SETTING)
                add_token();
            foreach (byte_plan[k])
                send_byte(byte_plan[k]);
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && row_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
